// ===== hw/rtl/ccmm_pkg.sv =====
package ccmm_pkg;

    localparam int DIM       = 3;
    localparam int FRAC_BITS = 30;

    localparam int NELEM   = DIM * DIM;
    localparam int IDX_W   = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int ADDR_W  = (NELEM > 1) ? $clog2(NELEM) : 1;
    localparam int INDEX_W = 4;
    localparam int DATA_W  = 32;
    localparam int WORD_W  = 2 * DATA_W;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int OUT_W   = 40;
    localparam int ACC_W   = 72;

    typedef enum logic [1:0] {
        TERM_RR,
        TERM_II,
        TERM_RI,
        TERM_IR
    } term_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_ACC,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic  clear;
        logic  mul_en;
        term_t mul_term;
        logic  acc_en;
        term_t acc_term;
    } mac_ctrl_t;

endpackage

// ===== hw/rtl/complex_conj_transpose_matmul_unit.sv =====
// Computes A = B^H * C for 3x3 complex matrices of signed Q1.30 elements. Each load item
// (start high while busy low) writes one element of B (op 0) or C (op 1) if its index is
// in range; busy stays low so loads can come every cycle. An item with start_compute set
// loads and then starts the product, and busy stays high while it runs: one shared 32x32
// multiplier forms the four partial products of each conj(b)*c term in turn after a
// registered store read, and each element ends in an output state that latches its
// result. The nine results come in row-major order, each on the output ports for exactly
// one cycle with valid high; the receiver cannot hold them off. The last one, with
// out_last set, shows in the same cycle busy falls. Results are exact sums floored to 30
// fraction bits in 40-bit signed words.
module complex_conj_transpose_matmul_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   op,
    input  logic [ccmm_pkg::INDEX_W-1:0]           elem_index,
    input  logic signed [ccmm_pkg::DATA_W-1:0]     elem_re,
    input  logic signed [ccmm_pkg::DATA_W-1:0]     elem_im,
    input  logic                                   start_compute,
    output logic                                   valid,
    output logic [ccmm_pkg::INDEX_W-1:0]           out_index,
    output logic signed [ccmm_pkg::OUT_W-1:0]      out_re,
    output logic signed [ccmm_pkg::OUT_W-1:0]      out_im,
    output logic                                   out_last
);
    import ccmm_pkg::*;

    state_t state_reg;
    state_t state_next;

    logic [IDX_W-1:0]  i_reg;
    logic [IDX_W-1:0]  j_reg;
    logic [IDX_W-1:0]  k_reg;
    logic [1:0]        term_cnt_reg;

    logic              accept;
    logic              in_range;
    logic              wr_b;
    logic              wr_c;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] b_addr;
    logic [ADDR_W-1:0] c_addr;
    logic [ADDR_W-1:0] res_addr;
    logic [WORD_W-1:0] wr_word;
    logic              k_last;
    logic              j_last;
    logic              i_last;
    logic              elem_last;
    logic              out_load;

    logic [WORD_W-1:0] mem_b [NELEM];
    logic [WORD_W-1:0] mem_c [NELEM];
    logic [WORD_W-1:0] b_rd_reg;
    logic [WORD_W-1:0] c_rd_reg;

    mac_ctrl_t         mac_ctrl;
    logic signed [OUT_W-1:0] res_re;
    logic signed [OUT_W-1:0] res_im;

    logic                    valid_reg;
    logic [INDEX_W-1:0]      out_index_reg;
    logic signed [OUT_W-1:0] out_re_reg;
    logic signed [OUT_W-1:0] out_im_reg;
    logic                    out_last_reg;

    assign accept   = start && !busy;
    assign in_range = 32'(elem_index) < NELEM;
    assign wr_addr  = ADDR_W'(elem_index);
    assign wr_word  = {elem_im, elem_re};
    assign wr_b     = accept && in_range && !op;
    assign wr_c     = accept && in_range && op;

    assign b_addr   = ADDR_W'(k_reg) * ADDR_W'(DIM) + ADDR_W'(i_reg);
    assign c_addr   = ADDR_W'(k_reg) * ADDR_W'(DIM) + ADDR_W'(j_reg);
    assign res_addr = ADDR_W'(i_reg) * ADDR_W'(DIM) + ADDR_W'(j_reg);

    assign k_last    = k_reg == IDX_W'(DIM - 1);
    assign j_last    = j_reg == IDX_W'(DIM - 1);
    assign i_last    = i_reg == IDX_W'(DIM - 1);
    assign elem_last = i_last && j_last;

    // element stores
    always_ff @(posedge clk)
    begin
        if (wr_b)
        begin
            mem_b[wr_addr] <= wr_word;
        end
        if (wr_c)
        begin
            mem_c[wr_addr] <= wr_word;
        end
        b_rd_reg <= mem_b[b_addr];
        c_rd_reg <= mem_c[c_addr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && start_compute)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (term_t'(term_cnt_reg) == TERM_IR)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                state_next = k_last ? ST_OUT : ST_READ;
            end
            ST_OUT:
            begin
                state_next = elem_last ? ST_IDLE : ST_READ;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        busy              = 1'b1;
        out_load          = 1'b0;
        mac_ctrl.clear    = 1'b0;
        mac_ctrl.mul_en   = 1'b0;
        mac_ctrl.mul_term = term_t'(term_cnt_reg);
        mac_ctrl.acc_en   = 1'b0;
        mac_ctrl.acc_term = term_t'(term_cnt_reg - 2'd1);
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_READ:
            begin
                mac_ctrl.clear = (k_reg == '0);
            end
            ST_MUL:
            begin
                mac_ctrl.mul_en = 1'b1;
                mac_ctrl.acc_en = (term_cnt_reg != 2'd0);
            end
            ST_ACC:
            begin
                mac_ctrl.acc_en   = 1'b1;
                mac_ctrl.acc_term = TERM_IR;
            end
            ST_OUT:
            begin
                out_load = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            term_cnt_reg <= '0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= out_load;
            if (state_reg == ST_MUL)
            begin
                term_cnt_reg <= term_cnt_reg + 2'd1;
            end
            else
            begin
                term_cnt_reg <= '0;
            end
            if (state_reg == ST_ACC)
            begin
                k_reg <= k_last ? '0 : k_reg + IDX_W'(1);
            end
            if (state_reg == ST_OUT)
            begin
                if (j_last)
                begin
                    j_reg <= '0;
                    i_reg <= i_last ? '0 : i_reg + IDX_W'(1);
                end
                else
                begin
                    j_reg <= j_reg + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_index_reg <= INDEX_W'(res_addr);
            out_re_reg    <= res_re;
            out_im_reg    <= res_im;
            out_last_reg  <= elem_last;
        end
    end

    ccmm_mac u_mac (
        .clk    (clk),
        .ctrl   (mac_ctrl),
        .b_re   (b_rd_reg[DATA_W-1:0]),
        .b_im   (b_rd_reg[WORD_W-1:DATA_W]),
        .c_re   (c_rd_reg[DATA_W-1:0]),
        .c_im   (c_rd_reg[WORD_W-1:DATA_W]),
        .res_re (res_re),
        .res_im (res_im)
    );

    assign valid     = valid_reg;
    assign out_index = out_index_reg;
    assign out_re    = out_re_reg;
    assign out_im    = out_im_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== hw/rtl/ccmm_mac.sv =====
module ccmm_mac (
    input  logic                                   clk,
    input  ccmm_pkg::mac_ctrl_t                    ctrl,
    input  logic signed [ccmm_pkg::DATA_W-1:0]     b_re,
    input  logic signed [ccmm_pkg::DATA_W-1:0]     b_im,
    input  logic signed [ccmm_pkg::DATA_W-1:0]     c_re,
    input  logic signed [ccmm_pkg::DATA_W-1:0]     c_im,
    output logic signed [ccmm_pkg::OUT_W-1:0]      res_re,
    output logic signed [ccmm_pkg::OUT_W-1:0]      res_im
);
    import ccmm_pkg::*;

    logic signed [DATA_W-1:0] mul_a;
    logic signed [DATA_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  acc_re_reg;
    logic signed [ACC_W-1:0]  acc_im_reg;
    logic signed [ACC_W-1:0]  acc_re_next;
    logic signed [ACC_W-1:0]  acc_im_next;

    // conj(b) * c = (br*cr + bi*ci) + i(br*ci - bi*cr)
    always_comb
    begin
        case (ctrl.mul_term)
            TERM_RR:
            begin
                mul_a = b_re;
                mul_b = c_re;
            end
            TERM_II:
            begin
                mul_a = b_im;
                mul_b = c_im;
            end
            TERM_RI:
            begin
                mul_a = b_re;
                mul_b = c_im;
            end
            default:
            begin
                mul_a = b_im;
                mul_b = c_re;
            end
        endcase
    end

    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign prod_ext  = {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_comb
    begin
        acc_re_next = acc_re_reg;
        acc_im_next = acc_im_reg;
        if (ctrl.clear)
        begin
            acc_re_next = '0;
            acc_im_next = '0;
        end
        else if (ctrl.acc_en)
        begin
            case (ctrl.acc_term) inside
                TERM_RR, TERM_II: acc_re_next = acc_re_reg + prod_ext;
                TERM_RI:          acc_im_next = acc_im_reg + prod_ext;
                default:          acc_im_next = acc_im_reg - prod_ext;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= prod_next;
        end
        acc_re_reg <= acc_re_next;
        acc_im_reg <= acc_im_next;
    end

    // floor shift by the fraction width
    assign res_re = acc_re_reg[FRAC_BITS +: OUT_W];
    assign res_im = acc_im_reg[FRAC_BITS +: OUT_W];

endmodule

// ===== hw/rtl/ccmm_checker.sv =====
module ccmm_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   start,
    input logic                                   busy,
    input logic                                   start_compute,
    input logic                                   valid,
    input logic                                   out_last
);

    // a compute item raises busy
    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && start_compute |=> busy)
    else $error("compute item did not raise busy");

    // a plain load item keeps the block free
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !start_compute |=> !busy)
    else $error("load item raised busy");

    // every item but the last arrives while busy
    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !out_last |-> busy)
    else $error("non-final item while idle");

    // busy drops exactly with the final item
    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> valid && out_last)
    else $error("busy fell without the final item");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        valid && out_last |-> !busy)
    else $error("final item while still busy");

endmodule

bind complex_conj_transpose_matmul_unit ccmm_checker u_ccmm_checker (.*);

// ===== verif/complex_conj_transpose_matmul_unit_tb.sv =====
`timescale 1ns / 100ps

module complex_conj_transpose_matmul_unit_tb;

    import ccmm_pkg::*;

    localparam logic OP_LOAD_B = 1'b0;
    localparam logic OP_LOAD_C = 1'b1;

    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;
    // every entry -2.0 - 2.0i in both matrices: each element is 3 * 2^63 >> 30
    localparam logic signed [OUT_W-1:0] CORNER_RE = 40'sh06_0000_0000;

    localparam int RAND_ITEMS  = 446;
    localparam int CALM_ITEMS  = 60;
    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct {
        logic                       op;
        logic [INDEX_W-1:0]         idx;
        logic signed [DATA_W-1:0]   re;
        logic signed [DATA_W-1:0]   im;
        logic                       go;
        logic                       typed_exp;
        logic signed [OUT_W-1:0]    exp_re;
        logic signed [OUT_W-1:0]    exp_im;
    } load_row_t;

    typedef struct {
        logic [INDEX_W-1:0]         idx;
        logic signed [OUT_W-1:0]    re;
        logic signed [OUT_W-1:0]    im;
        logic                       last;
    } product_elem_t;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    logic op;
    logic [INDEX_W-1:0] elem_index;
    logic signed [DATA_W-1:0] elem_re;
    logic signed [DATA_W-1:0] elem_im;
    logic start_compute;
    logic valid;
    logic [INDEX_W-1:0] out_index;
    logic signed [OUT_W-1:0] out_re;
    logic signed [OUT_W-1:0] out_im;
    logic out_last;

    logic signed [DATA_W-1:0] b_re [NELEM];
    logic signed [DATA_W-1:0] b_im [NELEM];
    logic signed [DATA_W-1:0] c_re [NELEM];
    logic signed [DATA_W-1:0] c_im [NELEM];

    product_elem_t product_q [$];
    load_row_t     dir_tab [$];

    int items_sent;
    int products_started;
    int elems_checked;
    int bad_count;
    int quiet_cycles;

    complex_conj_transpose_matmul_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .elem_index    (elem_index),
        .elem_re       (elem_re),
        .elem_im       (elem_im),
        .start_compute (start_compute),
        .valid         (valid),
        .out_index     (out_index),
        .out_re        (out_re),
        .out_im        (out_im),
        .out_last      (out_last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic load_row_t mk_row(logic o, int idx, logic signed [DATA_W-1:0] re,
                                         logic signed [DATA_W-1:0] im, logic go,
                                         logic typed_exp = 1'b0,
                                         logic signed [OUT_W-1:0] exp_re = '0,
                                         logic signed [OUT_W-1:0] exp_im = '0);
        load_row_t r;
        r.op = o;
        r.idx = INDEX_W'(idx);
        r.re = re;
        r.im = im;
        r.go = go;
        r.typed_exp = typed_exp;
        r.exp_re = exp_re;
        r.exp_im = exp_im;
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return Q_MIN;
            1: return Q_MAX;
            2: return '0;
            3: return -1;
            default: return $urandom;
        endcase
    endfunction

    function automatic void store_element(load_row_t r);
        if (r.idx < NELEM)
        begin
            if (r.op == OP_LOAD_B)
            begin
                b_re[r.idx] = r.re;
                b_im[r.idx] = r.im;
            end
            else
            begin
                c_re[r.idx] = r.re;
                c_im[r.idx] = r.im;
            end
        end
    endfunction

    // A = conj(B)^T * C, exact sums floored to FRAC_BITS fraction bits
    function automatic void predict_product();
        logic signed [ACC_W-1:0] acc_re;
        logic signed [ACC_W-1:0] acc_im;
        logic signed [PROD_W-1:0] p;
        product_elem_t e;
        for (int i = 0; i < DIM; i++)
        begin
            for (int j = 0; j < DIM; j++)
            begin
                acc_re = '0;
                acc_im = '0;
                for (int k = 0; k < DIM; k++)
                begin
                    p = PROD_W'(b_re[k*DIM+i]) * PROD_W'(c_re[k*DIM+j]);
                    acc_re = acc_re + ACC_W'(p);
                    p = PROD_W'(b_im[k*DIM+i]) * PROD_W'(c_im[k*DIM+j]);
                    acc_re = acc_re + ACC_W'(p);
                    p = PROD_W'(b_re[k*DIM+i]) * PROD_W'(c_im[k*DIM+j]);
                    acc_im = acc_im + ACC_W'(p);
                    p = PROD_W'(b_im[k*DIM+i]) * PROD_W'(c_re[k*DIM+j]);
                    acc_im = acc_im - ACC_W'(p);
                end
                e.idx = INDEX_W'(i*DIM + j);
                e.re = acc_re[FRAC_BITS +: OUT_W];
                e.im = acc_im[FRAC_BITS +: OUT_W];
                e.last = (i*DIM + j == NELEM - 1);
                product_q.push_back(e);
            end
        end
    endfunction

    function automatic void push_typed(load_row_t r);
        product_elem_t e;
        for (int n = 0; n < NELEM; n++)
        begin
            e.idx = INDEX_W'(n);
            e.re = r.exp_re;
            e.im = r.exp_im;
            e.last = (n == NELEM - 1);
            product_q.push_back(e);
        end
    endfunction

    task automatic send_item(load_row_t r);
        @(negedge clk);
        start <= 1'b1;
        op <= r.op;
        elem_index <= r.idx;
        elem_re <= r.re;
        elem_im <= r.im;
        start_compute <= r.go;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
        store_element(r);
        if (r.go)
        begin
            products_started++;
            if (r.typed_exp)
                push_typed(r);
            else
                predict_product();
        end
    endtask

    // start low, noise on the item ports
    task automatic hold_off(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start <= 1'b0;
            op <= 1'($urandom_range(0, 1));
            elem_index <= INDEX_W'($urandom);
            elem_re <= $urandom;
            elem_im <= $urandom;
            start_compute <= 1'($urandom_range(0, 1));
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (product_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic report(string field, logic [63:0] exp_v, logic [63:0] act_v);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
        bad_count++;
    endtask

    always @(posedge clk)
    begin
        product_elem_t e;
        if (rst_n)
        begin
            if (valid)
            begin
                if (product_q.size() == 0)
                begin
                    $display("%0t: unexpected result, index %0d re %0h im %0h", $time,
                             out_index, out_re, out_im);
                    bad_count++;
                end
                else
                begin
                    e = product_q.pop_front();
                    elems_checked++;
                    if (out_index !== e.idx)
                        report("out_index", 64'(e.idx), 64'(out_index));
                    if (out_re !== e.re)
                        report("out_re", 64'(e.re), 64'(out_re));
                    if (out_im !== e.im)
                        report("out_im", 64'(e.im), 64'(out_im));
                    if (out_last !== e.last)
                        report("out_last", 64'(e.last), 64'(out_last));
                end
            end
            if ((start && !busy) || valid)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: timeout, %0d results still expected", $time, product_q.size());
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        load_row_t r;
        bit calm;
        rst_n = 1'b0;
        start = 1'b0;
        op = OP_LOAD_B;
        elem_index = '0;
        elem_re = '0;
        elem_im = '0;
        start_compute = 1'b0;
        items_sent = 0;
        products_started = 0;
        elems_checked = 0;
        bad_count = 0;
        quiet_cycles = 0;
        calm = 1'b0;
        for (int n = 0; n < NELEM; n++)
        begin
            b_re[n] = '0;
            b_im[n] = '0;
            c_re[n] = '0;
            c_im[n] = '0;
        end

        // fill both matrices with -2.0 - 2.0i, then the corner product
        for (int n = 0; n < NELEM; n++)
            dir_tab.push_back(mk_row(OP_LOAD_B, n, Q_MIN, Q_MIN, 1'b0));
        for (int n = 0; n < NELEM; n++)
            dir_tab.push_back(mk_row(OP_LOAD_C, n, Q_MIN, Q_MIN, n == NELEM - 1,
                                     1'b1, CORNER_RE, '0));
        // out of range index writes nothing, compute still runs
        dir_tab.push_back(mk_row(OP_LOAD_C, 15, Q_MAX, Q_MAX, 1'b1, 1'b1, CORNER_RE, '0));
        dir_tab.push_back(mk_row(OP_LOAD_B, 9, '0, '0, 1'b0));
        dir_tab.push_back(mk_row(OP_LOAD_B, 4, Q_MAX, Q_MIN, 1'b0));
        dir_tab.push_back(mk_row(OP_LOAD_C, 0, '0, Q_MAX, 1'b0));
        dir_tab.push_back(mk_row(OP_LOAD_B, 0, -1, 1, 1'b1));
        dir_tab.push_back(mk_row(OP_LOAD_C, 8, Q_MAX, Q_MAX, 1'b1));

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_tab[n])
            send_item(dir_tab[n]);
        wait_drained();

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n % 40 == 0)
                calm = $urandom_range(0, 2) == 0;
            if (n > 0 && n % 100 == 0 && n < RAND_ITEMS - CALM_ITEMS)
                wait_drained();
            if (n < RAND_ITEMS - CALM_ITEMS && !calm && $urandom_range(0, 3) == 0)
                hold_off($urandom_range(1, 7));
            r.op = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 11) != 0)
                r.idx = INDEX_W'($urandom_range(0, NELEM - 1));
            else
                r.idx = INDEX_W'($urandom_range(NELEM, 15));
            r.re = pick_value();
            r.im = pick_value();
            r.go = $urandom_range(0, 9) == 0;
            r.typed_exp = 1'b0;
            r.exp_re = '0;
            r.exp_im = '0;
            send_item(r);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d load items sent, %0d products started, %0d result elements checked",
                 items_sent, products_started, elems_checked);
        $display("covered corner values, out of range indexes, back to back and idle loads");
        if (bad_count == 0 && product_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
